// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the tent filter kernel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define TFKG_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never occurs at a clock edge outside reset.
`define TFKG_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== src/tfkg_pkg.sv =====
// Package of types, constants and table functions for the tent filter kernel generator.
`default_nettype none

package tfkg_pkg;

   localparam int TAP_W   = 4;   // request size field
   localparam int IDX_W   = 3;   // column and row index
   localparam int AXW_W   = 3;   // axis weight, at most 4
   localparam int CELL_W  = 5;   // raw cell weight, at most 16
   localparam int SUM_W   = 5;   // axis weight sum, at most 20
   localparam int TOTAL_W = 9;   // kernel weight sum, at most 400
   localparam int NUM_W   = 20;  // cell weight times full scale
   localparam int REM_W   = TOTAL_W + 1;
   localparam int CNT_W   = 5;
   localparam int WGT_W   = 16;

   localparam logic [TAP_W-1:0] HW_TAP_LIMIT = 4'd8;
   localparam logic [CNT_W-1:0] DIV_LAST     = CNT_W'(NUM_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;  // latch clamped sizes, clear counters
      logic setup;    // latch kernel weight sum
      logic load;     // load divider with the current cell
      logic step;     // one restoring division step
      logic emit;     // register the word and advance the cell
   } cmd_type;

   typedef struct packed {
      logic empty;     // kernel has no cells
      logic div_done;  // last division step in progress
      logic cell_last; // current cell is the final one
   } status_type;

   // Sum of the axis weights of an axis of n taps.
   function automatic logic [SUM_W-1:0] axis_sum(input logic [TAP_W-1:0] n);
      logic [SUM_W-1:0] s;
      case (n)
         4'd1:    s = 5'd1;
         4'd2:    s = 5'd2;
         4'd3:    s = 5'd4;
         4'd4:    s = 5'd6;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd12;
         4'd7:    s = 5'd16;
         4'd8:    s = 5'd20;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Axis weight min(i+1, n-i) of index i in an axis of n taps.
   function automatic logic [AXW_W-1:0] axis_weight(input logic [IDX_W-1:0] i,
                                                    input logic [TAP_W-1:0] n);
      logic [TAP_W-1:0] up;
      logic [TAP_W-1:0] down;
      up   = {1'b0, i} + 4'd1;
      down = n - {1'b0, i};
      return (up < down) ? up[AXW_W-1:0] : down[AXW_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/tfkg_ctrl.sv =====
// Controller state machine that sequences setup, division and output of each weight.
`default_nettype none

module tfkg_ctrl
   import tfkg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.cell_last ? ST_IDLE : ST_LOAD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/tfkg_dpath.sv =====
// Datapath: size capture, cell counters, weight sum and iterative restoring divider.
`default_nettype none

module tfkg_dpath
   import tfkg_pkg::*;
#(
   parameter int MAX_TAPS = 8
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire logic [TAP_W-1:0] req_taps_x,
   input  wire logic [TAP_W-1:0] req_taps_y,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [WGT_W-1:0]      rsp_weight,
   output logic [IDX_W-1:0]      rsp_col,
   output logic [IDX_W-1:0]      rsp_row,
   output logic                  rsp_last
);

   localparam logic [TAP_W-1:0] TAP_LIMIT =
      (MAX_TAPS > 8) ? HW_TAP_LIMIT : TAP_W'(MAX_TAPS);

   logic [TAP_W-1:0]   nx_ff, ny_ff;
   logic [IDX_W-1:0]   col_ff, row_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [NUM_W-1:0]   dq_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               valid_ff;
   logic [WGT_W-1:0]   weight_ff;
   logic [IDX_W-1:0]   col_out_ff, row_out_ff;
   logic               last_out_ff;

   logic [TAP_W-1:0]      nx_in, ny_in;
   logic                  col_end, row_end;
   logic [2*SUM_W-1:0]    total_in;
   logic [2*AXW_W-1:0]    cell_prod;
   logic [CELL_W-1:0]     cell_w;
   logic [NUM_W:0]        num_wide;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      rem_diff;
   logic                  q_bit;

   // Clamp sizes to the tap limit
   assign nx_in = (req_taps_x > TAP_LIMIT) ? TAP_LIMIT : req_taps_x;
   assign ny_in = (req_taps_y > TAP_LIMIT) ? TAP_LIMIT : req_taps_y;

   // Cell position flags
   assign col_end = ({1'b0, col_ff} == nx_ff - 4'd1);
   assign row_end = ({1'b0, row_ff} == ny_ff - 4'd1);

   // Kernel sum is the product of the two axis sums
   assign total_in = axis_sum(nx_ff) * axis_sum(ny_ff);

   // Raw cell weight times full scale, as a shift and subtract
   assign cell_prod = axis_weight(col_ff, nx_ff) * axis_weight(row_ff, ny_ff);
   assign cell_w    = cell_prod[CELL_W-1:0];
   assign num_wide  = {cell_w, {WGT_W{1'b0}}} - {{(NUM_W + 1 - CELL_W){1'b0}}, cell_w};

   // One restoring division step
   assign rem_shift = {rem_ff[REM_W-2:0], dq_ff[NUM_W-1]};
   assign q_bit     = (rem_shift >= {1'b0, total_ff});
   assign rem_diff  = rem_shift - {1'b0, total_ff};

   assign status.empty     = (nx_ff == '0) || (ny_ff == '0);
   assign status.div_done  = (cnt_ff == DIV_LAST);
   assign status.cell_last = col_end && row_end;

   // Capture sizes and step through the cells
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.emit) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_ff + 3'd1;
         end else begin
            col_ff <= col_ff + 3'd1;
         end
      end
      if (cmd.setup) begin
         total_ff <= total_in[TOTAL_W-1:0];
      end
   end

   // Load and iterate the divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dq_ff  <= num_wide[NUM_W-1:0];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         dq_ff  <= {dq_ff[NUM_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff : rem_shift;
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   // Strobe the result word for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         weight_ff   <= dq_ff[WGT_W-1:0];
         col_out_ff  <= col_ff;
         row_out_ff  <= row_ff;
         last_out_ff <= col_end && row_end;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_weight = weight_ff;
   assign rsp_col    = col_out_ff;
   assign rsp_row    = row_out_ff;
   assign rsp_last   = last_out_ff;

endmodule

`default_nettype wire

// ===== src/tent_filter_kernel_generator.sv =====
// Top level of the tent filter kernel generator: controller, datapath and checks.
//
// A request (start high while busy is low) gives the kernel width and height;
// sizes above the tap limit are clamped and a zero size yields no words.
// The block then emits one word per kernel cell in row-major order, each
// shown for exactly one cycle on rsp_valid; the receiver cannot stall it.
// A request first passes a capture and a setup step; then, for each cell, the
// controller loads the shared one-bit-per-cycle restoring divider, runs its 20
// steps and registers the output word. busy stays high until the last word is
// registered; a new request is taken after that.
`default_nettype none

module tent_filter_kernel_generator
   import tfkg_pkg::*;
#(
   parameter int MAX_TAPS = 8
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [TAP_W-1:0] req_taps_x,
   input  wire logic [TAP_W-1:0] req_taps_y,
   output logic                  rsp_valid,
   output logic [WGT_W-1:0]      rsp_weight,
   output logic [IDX_W-1:0]      rsp_col,
   output logic [IDX_W-1:0]      rsp_row,
   output logic                  rsp_last
);

   `include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;

   // Sequence the work
   tfkg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Compute the weights
   tfkg_dpath #(
      .MAX_TAPS (MAX_TAPS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_taps_x (req_taps_x),
      .req_taps_y (req_taps_y),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_weight (rsp_weight),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_last   (rsp_last)
   );

   // Checks on sequencing
   `TFKG_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
   `TFKG_ASSERT(a_word_spacing, rsp_valid |=> !rsp_valid, "result words too close together")
   `TFKG_ASSERT_NEVER(a_mid_idle, rsp_valid && !rsp_last && !busy, "idle before last word")
   `TFKG_ASSERT_NEVER(a_last_busy, rsp_valid && rsp_last && busy, "busy after last word")

endmodule

`default_nettype wire
